>>> sv/hhb_pkg.sv
// Shared types and constants for the hill hold brake ramp controller.
package hhb_pkg;

    // Field widths fixed by the interface.
    localparam int TimeW    = 32;
    localparam int GradW    = 15;
    localparam int MinGradW = 14;
    localparam int SpeedW   = 16;
    localparam int LevelW   = 10;
    localparam int HoldMsW  = 16;
    localparam int GearW    = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_MIN_GRADIENT    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED       = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_BRAKE_THRESHOLD = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ACCEL_THRESHOLD = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_HOLD_LEVEL      = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAX_HOLD_MS     = 3'd5;

    // Gear codes that allow a hold.
    localparam logic [GearW-1:0] HOLD_GEAR_REV = 3'd1;
    localparam logic [GearW-1:0] HOLD_GEAR_FWD = 3'd3;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_READY     = 2'd1,
        MODE_HOLDING   = 2'd2,
        MODE_RELEASING = 2'd3
    } mode_t;

    // What the result stage does with the commanded hold level.
    typedef enum logic [1:0] {
        HOLD_CLEAR = 2'd0,
        HOLD_KEEP  = 2'd1,
        HOLD_SET   = 2'd2,
        HOLD_RAMP  = 2'd3
    } hold_act_t;

    typedef struct packed {
        logic [MinGradW-1:0] min_gradient;
        logic [SpeedW-1:0]   max_speed;
        logic [LevelW-1:0]   brake_threshold;
        logic [LevelW-1:0]   accel_threshold;
        logic [LevelW-1:0]   hold_level;
        logic [HoldMsW-1:0]  max_hold_ms;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic               active;
        hold_act_t          act;
        logic [LevelW-1:0]  level;
    } fsm_word_t;

endpackage

>>> sv/hhb_cfg.sv
// Configuration register bank for the hill hold controller.
module hhb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [hhb_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [hhb_pkg::CfgDataW-1:0]   cfg_wr_data,
    output hhb_pkg::cfg_t                  cfg
);

    hhb_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_gradient    <= 14'd200;
            cfg_reg.max_speed       <= 16'd100;
            cfg_reg.brake_threshold <= 10'd50;
            cfg_reg.accel_threshold <= 10'd100;
            cfg_reg.hold_level      <= 10'd800;
            cfg_reg.max_hold_ms     <= 16'd3000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hhb_pkg::CFG_MIN_GRADIENT:
                    cfg_reg.min_gradient <= cfg_wr_data[hhb_pkg::MinGradW-1:0];
                hhb_pkg::CFG_MAX_SPEED:
                    cfg_reg.max_speed <= cfg_wr_data[hhb_pkg::SpeedW-1:0];
                hhb_pkg::CFG_BRAKE_THRESHOLD:
                    cfg_reg.brake_threshold <= cfg_wr_data[hhb_pkg::LevelW-1:0];
                hhb_pkg::CFG_ACCEL_THRESHOLD:
                    cfg_reg.accel_threshold <= cfg_wr_data[hhb_pkg::LevelW-1:0];
                hhb_pkg::CFG_HOLD_LEVEL:
                    cfg_reg.hold_level <= cfg_wr_data[hhb_pkg::LevelW-1:0];
                hhb_pkg::CFG_MAX_HOLD_MS:
                    cfg_reg.max_hold_ms <= cfg_wr_data[hhb_pkg::HoldMsW-1:0];
                default:
                begin
                    // Indexes past the bank are ignored.
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/hhb_fsm.sv
// Input register and hill hold state machine stage.
module hhb_fsm #(
    parameter int RELEASE_MS = 500,
    parameter int REM_W      = $clog2(RELEASE_MS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hhb_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hhb_pkg::TimeW-1:0]         now_ms,
    input  logic signed [hhb_pkg::GradW-1:0]  gradient,
    input  logic [hhb_pkg::SpeedW-1:0]        speed,
    input  logic [hhb_pkg::LevelW-1:0]        brake_level,
    input  logic [hhb_pkg::LevelW-1:0]        accel_level,
    input  logic [hhb_pkg::GearW-1:0]         gear_code,
    output logic                              s1_valid,
    input  logic                              s1_ready,
    output hhb_pkg::fsm_word_t                s1_word,
    output logic [REM_W-1:0]                  s1_rem
);

    localparam logic [hhb_pkg::TimeW-1:0] RelMsTime = hhb_pkg::TimeW'(RELEASE_MS);
    localparam logic [REM_W-1:0]          RelMsRem  = REM_W'(RELEASE_MS);

    // Input register.
    logic                              in_valid_reg;
    logic [hhb_pkg::TimeW-1:0]         now_reg;
    logic [hhb_pkg::GradW-1:0]         grad_reg;
    logic [hhb_pkg::SpeedW-1:0]        speed_reg;
    logic [hhb_pkg::LevelW-1:0]        brake_reg;
    logic [hhb_pkg::LevelW-1:0]        accel_reg;
    logic [hhb_pkg::GearW-1:0]         gear_reg;

    // Controller state.
    hhb_pkg::mode_t                    mode_reg, mode_next;
    logic                              was_pressed_reg;
    logic [hhb_pkg::TimeW-1:0]         hold_start_reg, hold_start_next;
    logic [hhb_pkg::TimeW-1:0]         rel_start_reg, rel_start_next;
    logic                              active_reg, active_next;

    // Output stage.
    logic                              s1_valid_reg;
    hhb_pkg::fsm_word_t                s1_word_reg;
    logic [REM_W-1:0]                  s1_rem_reg;

    logic                              s1_load, step, in_load;
    logic [hhb_pkg::GradW-1:0]         grad_mag;
    logic                              on_hill, stopped, pressed, released, drive;
    logic [hhb_pkg::TimeW-1:0]         hold_elapsed, rel_elapsed;
    logic                              hold_done, ramp_done;
    logic [REM_W-1:0]                  rem_next;
    hhb_pkg::hold_act_t                act;

    assign s1_load  = !s1_valid_reg || s1_ready;
    assign step     = in_valid_reg && s1_load;
    assign in_load  = !in_valid_reg || step;
    assign in_stall = !in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            now_reg   <= now_ms;
            grad_reg  <= gradient;
            speed_reg <= speed;
            brake_reg <= brake_level;
            accel_reg <= accel_level;
            gear_reg  <= gear_code;
        end
    end

    // Magnitude of the two's complement gradient; the most negative code maps to 16384.
    assign grad_mag = grad_reg[hhb_pkg::GradW-1] ?
                      (hhb_pkg::GradW'(0) - grad_reg) : grad_reg;

    assign on_hill  = grad_mag >= {1'b0, cfg.min_gradient};
    assign stopped  = speed_reg < cfg.max_speed;
    assign pressed  = brake_reg > cfg.brake_threshold;
    assign released = was_pressed_reg && !pressed;
    assign drive    = (gear_reg == hhb_pkg::HOLD_GEAR_REV) ||
                      (gear_reg == hhb_pkg::HOLD_GEAR_FWD);

    // Elapsed times wrap with the timestamp.
    assign hold_elapsed = now_reg - hold_start_reg;
    assign rel_elapsed  = now_reg - rel_start_reg;
    assign hold_done    = (hold_elapsed >= {16'd0, cfg.max_hold_ms}) ||
                          (accel_reg > cfg.accel_threshold);
    assign ramp_done    = rel_elapsed >= RelMsTime;
    assign rem_next     = RelMsRem - rel_elapsed[REM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= hhb_pkg::MODE_OFF;
            was_pressed_reg <= 1'b0;
            hold_start_reg  <= '0;
            rel_start_reg   <= '0;
            active_reg      <= 1'b0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            was_pressed_reg <= pressed;
            hold_start_reg  <= hold_start_next;
            rel_start_reg   <= rel_start_next;
            active_reg      <= active_next;
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        hold_start_next = hold_start_reg;
        rel_start_next  = rel_start_reg;
        active_next     = active_reg;
        act             = hhb_pkg::HOLD_KEEP;
        unique case (mode_reg)
            hhb_pkg::MODE_OFF:
            begin
                if (on_hill && stopped && drive)
                begin
                    mode_next = hhb_pkg::MODE_READY;
                end
                active_next = 1'b0;
                act         = hhb_pkg::HOLD_CLEAR;
            end
            hhb_pkg::MODE_READY:
            begin
                if (released)
                begin
                    hold_start_next = now_reg;
                    mode_next       = hhb_pkg::MODE_HOLDING;
                end
                // Leaving the hill or moving off cancels, even on a release.
                if (!on_hill || !stopped)
                begin
                    mode_next = hhb_pkg::MODE_OFF;
                end
            end
            hhb_pkg::MODE_HOLDING:
            begin
                active_next = 1'b1;
                act         = hhb_pkg::HOLD_SET;
                if (hold_done)
                begin
                    rel_start_next = now_reg;
                    mode_next      = hhb_pkg::MODE_RELEASING;
                end
            end
            hhb_pkg::MODE_RELEASING:
            begin
                if (ramp_done)
                begin
                    active_next = 1'b0;
                    act         = hhb_pkg::HOLD_CLEAR;
                    mode_next   = hhb_pkg::MODE_OFF;
                end
                else
                begin
                    act = hhb_pkg::HOLD_RAMP;
                end
            end
            default:
            begin
                mode_next = hhb_pkg::MODE_OFF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_word_reg.mode   <= mode_next;
            s1_word_reg.active <= active_next;
            s1_word_reg.act    <= act;
            s1_word_reg.level  <= cfg.hold_level;
            s1_rem_reg         <= rem_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_word  = s1_word_reg;
    assign s1_rem   = s1_rem_reg;

endmodule

>>> sv/hhb_ramp.sv
// Release ramp arithmetic pipeline and result register.
module hhb_ramp #(
    parameter int RELEASE_MS = 500,
    parameter int REM_W      = $clog2(RELEASE_MS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    output logic                          s1_ready,
    input  hhb_pkg::fsm_word_t            s1_word,
    input  logic [REM_W-1:0]              s1_rem,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    mode,
    output logic [hhb_pkg::LevelW-1:0]    hold_out,
    output logic                          active
);

    // Division by RELEASE_MS as a multiply by a rounded-up reciprocal; exact
    // for every product below 2**ProdW.
    localparam int ProdW  = hhb_pkg::LevelW + REM_W;
    localparam int ShiftW = ProdW + $clog2(RELEASE_MS);
    localparam int RecipW = ProdW + 1;
    localparam int QuotW  = ProdW + RecipW;
    localparam logic [63:0] Recip64 =
        ((64'd1 << ShiftW) + 64'(RELEASE_MS) - 64'd1) / 64'(RELEASE_MS);
    localparam logic [RecipW-1:0] Recip = Recip64[RecipW-1:0];

    logic                          s2_valid_reg, s3_valid_reg, out_valid_reg;
    hhb_pkg::fsm_word_t            s2_word_reg, s3_word_reg;
    logic [ProdW-1:0]              prod_reg;
    logic [QuotW-1:0]              quot_reg;
    logic [1:0]                    mode_reg;
    logic [hhb_pkg::LevelW-1:0]    hold_reg, hold_next;
    logic                          active_reg;
    logic                          s2_load, s3_load, out_load;

    assign out_load = !out_valid_reg || !out_stall;
    assign s3_load  = !s3_valid_reg || out_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_ready = s2_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (s3_load)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Hold level times the remaining ramp time.
    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid)
        begin
            s2_word_reg <= s1_word;
            prod_reg    <= ProdW'(s1_word.level) * ProdW'(s1_rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load && s2_valid_reg)
        begin
            s3_word_reg <= s2_word_reg;
            quot_reg    <= QuotW'(prod_reg) * QuotW'(Recip);
        end
    end

    always_comb
    begin
        unique case (s3_word_reg.act)
            hhb_pkg::HOLD_CLEAR: hold_next = '0;
            hhb_pkg::HOLD_KEEP:  hold_next = hold_reg;
            hhb_pkg::HOLD_SET:   hold_next = s3_word_reg.level;
            hhb_pkg::HOLD_RAMP:  hold_next = quot_reg[ShiftW +: hhb_pkg::LevelW];
            default:             hold_next = hold_reg;
        endcase
    end

    // The result register also holds the current hold level that ready keeps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= hhb_pkg::MODE_OFF;
            hold_reg   <= '0;
            active_reg <= 1'b0;
        end
        else if (out_load && s3_valid_reg)
        begin
            mode_reg   <= s3_word_reg.mode;
            hold_reg   <= hold_next;
            active_reg <= s3_word_reg.active;
        end
    end

    assign out_valid = out_valid_reg;
    assign mode      = mode_reg;
    assign hold_out  = hold_reg;
    assign active    = active_reg;

endmodule

>>> sv/hill_hold_brake_ramp_fsm.sv
// Top level of the hill hold controller with a linear brake release ramp.
//
// Usage: each input word is one control tick (timestamp, gradient, speed,
// pedal levels and gear). It is taken at a rising edge where in_valid is high
// and in_stall is low. Every tick yields exactly one result word (mode,
// hold_out, active), offered on out_valid and taken when out_stall is low.
// From acceptance to out_valid the word passes the input register, the
// state machine stage, the hold times remaining-time multiply and the
// reciprocal multiply before it lands in the result register.
// Throughput is one word per cycle while out_stall stays low; consecutive
// ticks then flow back to back. When the receiver stalls,
// words collect in the five pipeline registers and in_stall rises only once
// all of them are full.
// Reset clears all valid bits, puts the controller in off with zero hold and
// loads the documented register defaults. Configuration writes land at once
// and are meant to be made while no tick is in flight.
module hill_hold_brake_ramp_fsm #(
    parameter int RELEASE_MS = 500
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [hhb_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [hhb_pkg::CfgDataW-1:0]      cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hhb_pkg::TimeW-1:0]         now_ms,
    input  logic signed [hhb_pkg::GradW-1:0]  gradient,
    input  logic [hhb_pkg::SpeedW-1:0]        speed,
    input  logic [hhb_pkg::LevelW-1:0]        brake_level,
    input  logic [hhb_pkg::LevelW-1:0]        accel_level,
    input  logic [hhb_pkg::GearW-1:0]         gear_code,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        mode,
    output logic [hhb_pkg::LevelW-1:0]        hold_out,
    output logic                              active
);

    // Remaining ramp time spans 1 to RELEASE_MS.
    localparam int RemW = $clog2(RELEASE_MS + 1);

    hhb_pkg::cfg_t       cfg;
    logic                s1_valid;
    logic                s1_ready;
    hhb_pkg::fsm_word_t  s1_word;
    logic [RemW-1:0]     s1_rem;

    hhb_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Tick decode and mode transitions.
    hhb_fsm #(
        .RELEASE_MS (RELEASE_MS),
        .REM_W      (RemW)
    ) u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .now_ms      (now_ms),
        .gradient    (gradient),
        .speed       (speed),
        .brake_level (brake_level),
        .accel_level (accel_level),
        .gear_code   (gear_code),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_word     (s1_word),
        .s1_rem      (s1_rem)
    );

    // Ramp arithmetic and the result word register.
    hhb_ramp #(
        .RELEASE_MS (RELEASE_MS),
        .REM_W      (RemW)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_word   (s1_word),
        .s1_rem    (s1_rem),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mode      (mode),
        .hold_out  (hold_out),
        .active    (active)
    );

endmodule

>>> sv/hhb_checker.sv
// Port level checks for the hill hold controller and their bind.
module hhb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    mode,
    input  logic [hhb_pkg::LevelW-1:0]    hold_out,
    input  logic                          active
);

    logic [1:0] last_mode_reg;

    // Mode of the last word taken by the receiver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mode_reg <= hhb_pkg::MODE_OFF;
        end
        else if (out_valid && !out_stall)
        begin
            last_mode_reg <= mode;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mode) && $stable(hold_out)
            && $stable(active))
        else $error("result word changed while stalled");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode == hhb_pkg::MODE_OFF || mode == hhb_pkg::MODE_READY)
            |-> !active && hold_out == '0)
        else $error("hold commanded while off or ready");

    a_release_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode == hhb_pkg::MODE_RELEASING |-> active)
        else $error("releasing without active flag");

    a_legal_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (last_mode_reg == hhb_pkg::MODE_OFF &&
                (mode == hhb_pkg::MODE_OFF || mode == hhb_pkg::MODE_READY)) ||
            (last_mode_reg == hhb_pkg::MODE_READY &&
                mode != hhb_pkg::MODE_RELEASING) ||
            (last_mode_reg == hhb_pkg::MODE_HOLDING &&
                (mode == hhb_pkg::MODE_HOLDING || mode == hhb_pkg::MODE_RELEASING)) ||
            (last_mode_reg == hhb_pkg::MODE_RELEASING &&
                (mode == hhb_pkg::MODE_RELEASING || mode == hhb_pkg::MODE_OFF)))
        else $error("illegal mode sequence between result words");

endmodule

bind hill_hold_brake_ramp_fsm hhb_checker u_hhb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mode      (mode),
    .hold_out  (hold_out),
    .active    (active)
);

>>> verif/testbench.sv
// Self-checking testbench for the hill hold brake ramp controller.
module testbench;

    // The block's release ramp length, and the margins of the run.
    localparam int RampMs      = 500;
    localparam int DrainWait   = 8;
    localparam int QuietLimit  = 200;
    localparam int RandomTicks = 420;
    localparam int CalmTail    = 60;

    // Register indexes past the end of the list: the block drops such writes.
    localparam logic [hhb_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [hhb_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

    // Gear codes that never allow a hold.
    localparam logic [hhb_pkg::GearW-1:0] GEAR_PARK    = 3'd0;
    localparam logic [hhb_pkg::GearW-1:0] GEAR_NEUTRAL = 3'd2;
    localparam logic [hhb_pkg::GearW-1:0] GEAR_NONE    = 3'd7;

    // One control tick as it is driven onto the input ports.
    typedef struct packed {
        logic [hhb_pkg::TimeW-1:0]  now;
        logic [hhb_pkg::GradW-1:0]  grad;
        logic [hhb_pkg::SpeedW-1:0] spd;
        logic [hhb_pkg::LevelW-1:0] brake;
        logic [hhb_pkg::LevelW-1:0] accel;
        logic [hhb_pkg::GearW-1:0]  gear;
    } tick_t;

    // One brake command as the block reports it.
    typedef struct packed {
        logic [1:0]                 mode;
        logic [hhb_pkg::LevelW-1:0] hold;
        logic                       active;
    } hold_cmd_t;

    // Every input is known from time zero.
    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                cfg_wr_en   = 1'b0;
    logic [hhb_pkg::CfgIdxW-1:0]         cfg_index   = '0;
    logic [hhb_pkg::CfgDataW-1:0]        cfg_wr_data = '0;
    logic                                in_valid    = 1'b0;
    logic [hhb_pkg::TimeW-1:0]           now_ms      = '0;
    logic signed [hhb_pkg::GradW-1:0]    gradient    = '0;
    logic [hhb_pkg::SpeedW-1:0]          speed       = '0;
    logic [hhb_pkg::LevelW-1:0]          brake_level = '0;
    logic [hhb_pkg::LevelW-1:0]          accel_level = '0;
    logic [hhb_pkg::GearW-1:0]           gear_code   = '0;
    logic                                out_stall   = 1'b0;
    logic                                in_stall;
    logic                                out_valid;
    logic [1:0]                          mode;
    logic [hhb_pkg::LevelW-1:0]          hold_out;
    logic                                active;

    hill_hold_brake_ramp_fsm #(
        .RELEASE_MS(RampMs)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .now_ms     (now_ms),
        .gradient   (gradient),
        .speed      (speed),
        .brake_level(brake_level),
        .accel_level(accel_level),
        .gear_code  (gear_code),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mode       (mode),
        .hold_out   (hold_out),
        .active     (active)
    );

    always #5 clk = ~clk;

    // Ticks waiting to be driven, and brake commands still owed by the block.
    tick_t     tick_queue[$];
    hold_cmd_t expected_cmds[$];

    // Our own copy of the controller: its registers and its state.
    hhb_pkg::cfg_t  regs = '{min_gradient: 14'd200, max_speed: 16'd100,
                             brake_threshold: 10'd50, accel_threshold: 10'd100,
                             hold_level: 10'd800, max_hold_ms: 16'd3000};
    hhb_pkg::mode_t ctl_mode   = hhb_pkg::MODE_OFF;
    bit             brake_held = 1'b0;
    logic [31:0]    hold_since = '0;
    logic [31:0]    ramp_since = '0;
    logic [9:0]     cmd_hold   = '0;
    bit             cmd_active = 1'b0;

    // Bookkeeping shared between the stimulus, the driver and the monitor.
    bit          idle_on    = 1'b1;
    bit          in_taken   = 1'b0;
    int          gap_left   = 0;
    int          stall_left = 0;
    int          quiet      = 0;
    int          errors     = 0;
    int          queued_ticks    = 0;
    int          results_checked = 0;
    int          settings_run    = 0;
    int          ramps_started   = 0;
    logic [31:0] clock_ms   = '0;

    // Advances the controller by one tick and returns the command it should emit.
    // The brake edge is tracked on every tick, whatever the state, and a lost hill
    // or a moving vehicle in ready overrides a release edge on the same tick.
    function automatic hold_cmd_t step_controller(tick_t t);
        logic [15:0] gmag;
        logic [31:0] held_for;
        logic [31:0] ramp_age;
        bit          on_hill;
        bit          stopped;
        bit          pressed;
        bit          let_go;
        bit          in_gear;
        hold_cmd_t   r;
        gmag    = t.grad[hhb_pkg::GradW-1] ? (16'h8000 - {1'b0, t.grad}) : {1'b0, t.grad};
        on_hill = gmag >= {2'b00, regs.min_gradient};
        stopped = t.spd < regs.max_speed;
        pressed = t.brake > regs.brake_threshold;
        let_go  = brake_held && !pressed;
        in_gear = (t.gear == hhb_pkg::HOLD_GEAR_REV) || (t.gear == hhb_pkg::HOLD_GEAR_FWD);
        brake_held = pressed;
        case (ctl_mode)
            hhb_pkg::MODE_OFF:
            begin
                if (on_hill && stopped && in_gear)
                    ctl_mode = hhb_pkg::MODE_READY;
                cmd_hold   = '0;
                cmd_active = 1'b0;
            end
            hhb_pkg::MODE_READY:
            begin
                if (let_go)
                begin
                    hold_since = t.now;
                    ctl_mode   = hhb_pkg::MODE_HOLDING;
                end
                if (!on_hill || !stopped)
                    ctl_mode = hhb_pkg::MODE_OFF;
            end
            hhb_pkg::MODE_HOLDING:
            begin
                cmd_hold   = regs.hold_level;
                cmd_active = 1'b1;
                held_for   = t.now - hold_since;
                if (held_for >= {16'd0, regs.max_hold_ms} || t.accel > regs.accel_threshold)
                begin
                    ramp_since = t.now;
                    ctl_mode   = hhb_pkg::MODE_RELEASING;
                    ramps_started++;
                end
            end
            default:
            begin
                // Elapsed times are taken modulo 2^32, so a wrapped clock is harmless.
                ramp_age = t.now - ramp_since;
                if (ramp_age >= 32'(RampMs))
                begin
                    cmd_hold   = '0;
                    cmd_active = 1'b0;
                    ctl_mode   = hhb_pkg::MODE_OFF;
                end
                else
                    cmd_hold = hhb_pkg::LevelW'((32'(regs.hold_level) *
                                                 (32'(RampMs) - ramp_age)) / 32'(RampMs));
            end
        endcase
        r.mode   = ctl_mode;
        r.hold   = cmd_hold;
        r.active = cmd_active;
        return r;
    endfunction

    // Register writes are made only while no word is in flight, so our copy of
    // the registers can be updated at once.
    task automatic write_reg(input logic [hhb_pkg::CfgIdxW-1:0] idx,
                             input logic [hhb_pkg::CfgDataW-1:0] data);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        case (idx)
            hhb_pkg::CFG_MIN_GRADIENT:
                regs.min_gradient    = data[hhb_pkg::MinGradW-1:0];
            hhb_pkg::CFG_MAX_SPEED:
                regs.max_speed       = data[hhb_pkg::SpeedW-1:0];
            hhb_pkg::CFG_BRAKE_THRESHOLD:
                regs.brake_threshold = data[hhb_pkg::LevelW-1:0];
            hhb_pkg::CFG_ACCEL_THRESHOLD:
                regs.accel_threshold = data[hhb_pkg::LevelW-1:0];
            hhb_pkg::CFG_HOLD_LEVEL:
                regs.hold_level      = data[hhb_pkg::LevelW-1:0];
            hhb_pkg::CFG_MAX_HOLD_MS:
                regs.max_hold_ms     = data[hhb_pkg::HoldMsW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Writes the whole register set. The unused upper data bits carry noise, and
    // one write goes to an index that the block must ignore.
    task automatic set_regs(input int mg, input int ms, input int bt, input int at,
                            input int hl, input int mh);
        logic [15:0] noise;
        noise = 16'($urandom);
        write_reg(noise[0] ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
        write_reg(hhb_pkg::CFG_MIN_GRADIENT, {noise[15:14], 14'(mg)});
        write_reg(hhb_pkg::CFG_MAX_SPEED, 16'(ms));
        write_reg(hhb_pkg::CFG_BRAKE_THRESHOLD, {noise[15:10], 10'(bt)});
        write_reg(hhb_pkg::CFG_ACCEL_THRESHOLD, {noise[14:9], 10'(at)});
        write_reg(hhb_pkg::CFG_HOLD_LEVEL, {noise[13:8], 10'(hl)});
        write_reg(hhb_pkg::CFG_MAX_HOLD_MS, 16'(mh));
        settings_run++;
    endtask

    // Holds the sender back until every owed command has come out, then lets the
    // pipeline settle before it returns.
    task automatic wait_drained();
        while (tick_queue.size() != 0 || in_valid || expected_cmds.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    function automatic void send(logic [31:0] now, int grad, int spd, int brake, int accel,
                                 logic [hhb_pkg::GearW-1:0] gear);
        tick_t t;
        t.now   = now;
        t.grad  = hhb_pkg::GradW'(grad);
        t.spd   = hhb_pkg::SpeedW'(spd);
        t.brake = hhb_pkg::LevelW'(brake);
        t.accel = hhb_pkg::LevelW'(accel);
        t.gear  = gear;
        tick_queue.push_back(t);
        queued_ticks++;
    endfunction

    function automatic logic [31:0] advance(int lo, int hi);
        clock_ms = clock_ms + $urandom_range(hi, lo);
        return clock_ms;
    endfunction

    // Field values picked against the current register settings.
    function automatic int hill_grad();
        int m;
        m = ($urandom_range(0, 3) == 0) ? int'(regs.min_gradient)
                                        : int'($urandom_range(16383, int'(regs.min_gradient)));
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic int flat_grad();
        int m;
        if (regs.min_gradient == 0)
            return 0;
        m = $urandom_range(int'(regs.min_gradient) - 1, 0);
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic int any_grad();
        return int'($signed(15'($urandom)));
    endfunction

    function automatic int stopped_speed();
        if (regs.max_speed == 0)
            return 0;
        return $urandom_range(int'(regs.max_speed) - 1, 0);
    endfunction

    function automatic int moving_speed();
        return $urandom_range(65535, int'(regs.max_speed));
    endfunction

    function automatic int pressed_brake();
        if (regs.brake_threshold >= 10'd1023)
            return 1023;
        return $urandom_range(1023, int'(regs.brake_threshold) + 1);
    endfunction

    function automatic int loose_brake();
        return $urandom_range(int'(regs.brake_threshold), 0);
    endfunction

    function automatic int idle_accel();
        return $urandom_range(int'(regs.accel_threshold), 0);
    endfunction

    function automatic int firm_accel();
        if (regs.accel_threshold >= 10'd1023)
            return 1023;
        return $urandom_range(1023, int'(regs.accel_threshold) + 1);
    endfunction

    function automatic logic [hhb_pkg::GearW-1:0] drive_gear();
        return $urandom_range(0, 1) ? hhb_pkg::HOLD_GEAR_FWD : hhb_pkg::HOLD_GEAR_REV;
    endfunction

    // A whole hill start: settle with the brake down, lift it, hold, then ramp
    // out. A few of them are broken off before the hold begins.
    function automatic void hill_hold_sequence();
        int          grad;
        int          n;
        logic [31:0] t0;
        logic [31:0] tr;
        grad = hill_grad();
        n = $urandom_range(1, 3);
        repeat (n)
            send(advance(1, 50), grad, stopped_speed(), pressed_brake(), idle_accel(),
                 drive_gear());
        case ($urandom_range(0, 9))
            0:
            begin
                // The brake is lifted on the tick that leaves the hill.
                send(advance(1, 50), flat_grad(), stopped_speed(), loose_brake(), idle_accel(),
                     drive_gear());
                return;
            end
            1:
            begin
                send(advance(1, 50), grad, moving_speed(), $urandom_range(1023, 0),
                     idle_accel(), drive_gear());
                return;
            end
            default: ;
        endcase
        t0 = advance(1, 50);
        send(t0, grad, stopped_speed(), loose_brake(), idle_accel(), drive_gear());
        n = $urandom_range(1, 5);
        repeat (n)
            send(advance(1, 400), any_grad(), $urandom_range(65535, 0), loose_brake(),
                 idle_accel(), 3'($urandom));
        if ($urandom_range(0, 1))
        begin
            // Let the hold run out, landing on or just past its limit unless the clock is already beyond it.
            if (clock_ms - t0 < {16'd0, regs.max_hold_ms})
                clock_ms = t0 + regs.max_hold_ms + $urandom_range(1, 0);
            send(clock_ms, any_grad(), $urandom_range(65535, 0), loose_brake(), idle_accel(),
                 3'($urandom));
        end
        else
            send(advance(1, 400), any_grad(), $urandom_range(65535, 0), loose_brake(),
                 firm_accel(), 3'($urandom));
        tr = clock_ms;
        while (clock_ms - tr < 32'(RampMs))
        begin
            case ($urandom_range(0, 7))
                0:       clock_ms = tr + RampMs - 1;
                1:       clock_ms = tr + RampMs;
                default: clock_ms = clock_ms + $urandom_range(150, 1);
            endcase
            send(clock_ms, any_grad(), $urandom_range(65535, 0), $urandom_range(1023, 0),
                 $urandom_range(1023, 0), 3'($urandom));
        end
    endfunction

    function automatic void noise_tick();
        send($urandom, $urandom, $urandom, $urandom, $urandom, 3'($urandom));
    endfunction

    // Sender: a new word is presented only once the previous one has been taken,
    // so a stalled word never changes. Short gaps follow some words at random.
    always @(negedge clk)
    begin : drive_ticks
        tick_t nxt;
        if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (tick_queue.size() != 0)
            begin
                nxt = tick_queue.pop_front();
                in_valid    <= 1'b1;
                now_ms      <= nxt.now;
                gradient    <= nxt.grad;
                speed       <= nxt.spd;
                brake_level <= nxt.brake;
                accel_level <= nxt.accel;
                gear_code   <= nxt.gear;
                if (idle_on && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(3, 1);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stalls come in short random bursts that start only while idling is on.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(2, 0);
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: the result word is checked before the tick taken on the same edge
    // is predicted, since no tick can come out on the edge that takes it.
    always @(posedge clk)
    begin : watch_ports
        hold_cmd_t want;
        tick_t     seen;
        if (rst_n)
        begin
            in_taken = in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_cmds.size() == 0)
                begin
                    $error("result word with none owed: mode %0d hold_out %0d active %0d",
                           mode, hold_out, active);
                    errors++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (mode !== want.mode)
                    begin
                        $error("mode: expected %0d, got %0d", want.mode, mode);
                        errors++;
                    end
                    if (hold_out !== want.hold)
                    begin
                        $error("hold_out: expected %0d, got %0d", want.hold, hold_out);
                        errors++;
                    end
                    if (active !== want.active)
                    begin
                        $error("active: expected %0d, got %0d", want.active, active);
                        errors++;
                    end
                end
            end
            if (in_taken)
            begin
                seen = {now_ms, gradient, speed, brake_level, accel_level, gear_code};
                expected_cmds.push_back(step_controller(seen));
            end
        end
        else
            in_taken = 1'b0;
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QuietLimit)
        begin
            $display("watchdog: no word moved for %0d cycles", QuietLimit);
            $display("** hill_hold_brake_ramp_fsm: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int random_base;
        int phase;
        int phase_start;
        logic [31:0] h0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset settings. Gear checks: neutral, park and an
        // unknown code never arm the hold; reverse and drive do.
        send(32'd0, 0, 0, 0, 0, GEAR_NEUTRAL);
        send(32'd10, 200, 99, 60, 0, GEAR_PARK);
        send(32'd20, -200, 0, 60, 0, GEAR_NONE);
        send(32'd40, -16384, 0, 1023, 0, hhb_pkg::HOLD_GEAR_REV);
        // A release edge while moving: dropping to off wins over holding.
        send(32'd50, -16384, 100, 0, 0, hhb_pkg::HOLD_GEAR_REV);
        send(32'd60, 16383, 0, 51, 0, hhb_pkg::HOLD_GEAR_FWD);
        // Hold starts just before the timestamp wraps; accel at threshold is not enough.
        send(32'hFFFF_FE00, 16383, 0, 50, 1023, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0100, 0, 65535, 0, 100, GEAR_PARK);
        send(32'h0000_0200, 0, 0, 0, 101, hhb_pkg::HOLD_GEAR_FWD);
        // Ramp at its start, one step in, half way, its last step and its end.
        send(32'h0000_0200, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0201, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0200 + 250, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0200 + 499, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0200 + 500, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        // A hold that runs out exactly at its limit, with the ramp crossing the wrap.
        h0 = 32'hFFFF_FF80 - 32'd3000;
        send(32'd100, 300, 50, 900, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(h0, 300, 50, 10, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(h0 + 2999, 300, 50, 10, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(h0 + 3000, 300, 50, 10, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0080, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0174, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'h0000_0175, 0, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        wait_drained();

        // Enter the ramp, then change the hold level while it runs; the new level,
        // beyond the nominal range, must shape the rest of the ramp.
        send(32'd5000, 300, 0, 600, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'd5010, 300, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'd5020, 300, 0, 0, 500, hhb_pkg::HOLD_GEAR_FWD);
        send(32'd5100, 300, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        wait_drained();
        write_reg(hhb_pkg::CFG_HOLD_LEVEL, 16'd1023);
        settings_run++;
        send(32'd5200, 300, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);
        send(32'd5520, 300, 0, 0, 0, hhb_pkg::HOLD_GEAR_FWD);

        // Random part. Each phase starts with the sender held off until every
        // owed command is in, then a fresh register set. The first three phases
        // take the lowest, the highest and the reset settings.
        random_base = queued_ticks;
        clock_ms    = $urandom;
        phase       = 0;
        while (queued_ticks - random_base < RandomTicks)
        begin
            wait_drained();
            case (phase)
                0:       set_regs(0, 0, 0, 0, 0, 0);
                1:       set_regs(10000, 65535, 1000, 1000, 1000, 65535);
                2:       set_regs(200, 100, 50, 100, 800, 3000);
                default: set_regs($urandom_range(10000, 0), $urandom_range(65535, 1),
                                  $urandom_range(1000, 0), $urandom_range(1000, 0),
                                  $urandom_range(1000, 0),
                                  ($urandom_range(0, 4) != 0) ? $urandom_range(2000, 0)
                                                              : $urandom_range(65535, 0));
            endcase
            // The closing stretch runs with no idling at all; some earlier phases
            // run without it as well.
            if (queued_ticks - random_base >= RandomTicks - CalmTail)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            phase_start = queued_ticks;
            while (queued_ticks - phase_start < 40)
            begin
                if ($urandom_range(0, 3) == 0)
                    noise_tick();
                else
                    hill_hold_sequence();
            end
            phase++;
        end

        wait_drained();
        $display("Checked %0d result words from %0d ticks over %0d register settings.",
                 results_checked, queued_ticks, settings_run);
        $display("%0d holds went into the release ramp.", ramps_started);
        if (errors == 0)
            $display("** hill_hold_brake_ramp_fsm: PASSED **");
        else
            $display("** hill_hold_brake_ramp_fsm: FAILED **");
        $finish;
    end

endmodule
